/* design/aes_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and round functions for the AES block cipher.
// ---------------------------------------------------------------------------
package aes_pkg;

  localparam int MAX_ROUNDS = 14;
  localparam int RK_WORDS   = 4 * (MAX_ROUNDS + 1);
  localparam int RK_AW      = $clog2(RK_WORDS + 1);

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_KEY_LENGTH = 3'd0,
    CFG_KEY_WORD_0 = 3'd1,
    CFG_KEY_WORD_1 = 3'd2,
    CFG_KEY_WORD_2 = 3'd3,
    CFG_KEY_WORD_3 = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        opcode;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_hi;
    logic [63:0] out_lo;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [63:0] value;
  } cfg_item_t;

  // Per-stage round control
  typedef struct packed {
    logic last;
    logic bypass;
  } round_ctl_t;

  localparam logic [7:0] RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                      8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  localparam logic [2047:0] SBOX_FWD = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] SBOX_INV = {
    128'h52096ad53036a538bf40a39e81f3d7fb,
    128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e,
    128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692,
    128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506,
    128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673,
    128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b,
    128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f,
    128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961,
    128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox_fwd(input logic [7:0] b);
    return SBOX_FWD[2047 - 8 * b -: 8];
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] b);
    return SBOX_INV[2047 - 8 * b -: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox_fwd(w[31:24]), sbox_fwd(w[23:16]), sbox_fwd(w[15:8]), sbox_fwd(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Multiply by a coefficient of up to four bits
  function automatic logic [7:0] gmul(input logic [7:0] x, input logic [3:0] y);
    logic [7:0] p;
    logic [7:0] a;
    p = 8'h00;
    a = x;
    for (int b = 0; b < 4; b++) begin
      if (y[b]) p = p ^ a;
      a = xtime(a);
    end
    return p;
  endfunction

  // Byte b of the state sits in the top bits for b = 0
  function automatic logic [7:0] st_byte(input logic [127:0] s, input int b);
    return s[127 - 8 * b -: 8];
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int           from;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        from = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
        t[127 - 8 * (c * 4 + r) -: 8] = inv ? sbox_inv(st_byte(s, from * 4 + r))
                                            : sbox_fwd(st_byte(s, from * 4 + r));
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_fwd(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a [4];
    logic [7:0]   all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) a[j] = st_byte(s, c * 4 + j);
      all = a[0] ^ a[1] ^ a[2] ^ a[3];
      for (int j = 0; j < 4; j++) begin
        t[127 - 8 * (c * 4 + j) -: 8] = a[j] ^ all ^ xtime(a[j] ^ a[(j + 1) & 3]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_inv(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a [4];
    logic [3:0]   coef [4];
    t = '0;
    coef[0] = 4'he;
    coef[1] = 4'h9;
    coef[2] = 4'hd;
    coef[3] = 4'hb;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) a[j] = st_byte(s, c * 4 + j);
      for (int j = 0; j < 4; j++) begin
        t[127 - 8 * (c * 4 + j) -: 8] = gmul(a[0], coef[j]) ^ gmul(a[1], coef[(j + 3) & 3]) ^
                                        gmul(a[2], coef[(j + 2) & 3]) ^
                                        gmul(a[3], coef[(j + 1) & 3]);
      end
    end
    return t;
  endfunction

endpackage
`default_nettype wire

/* design/aes_in_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// aes_in_if
// Input block channel: valid, ready and one block with its opcode.
// ---------------------------------------------------------------------------
interface aes_in_if import aes_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/aes_out_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// aes_out_if
// Result channel: valid, ready and one 128-bit result block.
// ---------------------------------------------------------------------------
interface aes_out_if import aes_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/aes_cfg_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// aes_cfg_if
// Configuration write channel: valid, ready, register index and value.
// ---------------------------------------------------------------------------
interface aes_cfg_if import aes_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/aes_key_expand.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// aes_key_expand
// Key registers and a one-word-per-cycle key schedule into round-key flops.
// ---------------------------------------------------------------------------
module aes_key_expand import aes_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  aes_cfg_if.sink    cfg_i,
  output logic [1:0] key_len_o,
  output logic       keys_ready_o,
  output logic [31:0] rk_o [RK_WORDS]
);

  logic [1:0]       klen_q;
  logic [63:0]      kw_q [4];
  logic             ready_q;
  logic [RK_AW-1:0] cnt_q;
  logic [2:0]       pos_q;
  logic [3:0]       rci_q;
  logic [31:0]      win_q [8];
  logic [31:0]      rk_q [RK_WORDS];

  logic             cfg_hit;
  logic             expand;
  logic [3:0]       nk;
  logic [RK_AW-1:0] total;
  logic [31:0]      t;
  logic [31:0]      w;

  assign cfg_i.ready = 1'b1;

  // Any write to a known register restarts the schedule
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_KEY_LENGTH, CFG_KEY_WORD_0, CFG_KEY_WORD_1,
        CFG_KEY_WORD_2, CFG_KEY_WORD_3: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  assign expand = !ready_q && !cfg_hit;

  always_comb begin
    case (klen_q)
      2'd0: begin
        nk    = 4'd4;
        total = RK_AW'(44);
      end
      2'd1: begin
        nk    = 4'd6;
        total = RK_AW'(52);
      end
      default: begin
        nk    = 4'd8;
        total = RK_AW'(60);
      end
    endcase
  end

  // Next schedule word
  always_comb begin
    t = win_q[0];
    if (pos_q == 3'd0) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {RCON[rci_q], 24'h0};
    end else if (nk == 4'd8 && pos_q == 3'd4) begin
      t = sub_word(t);
    end
    if (cnt_q < RK_AW'(nk)) begin
      w = cnt_q[0] ? kw_q[cnt_q[2:1]][31:0] : kw_q[cnt_q[2:1]][63:32];
    end else begin
      w = win_q[3'(nk - 4'd1)] ^ t;
    end
  end

  // Config registers and schedule control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q  <= 2'd0;
      for (int k = 0; k < 4; k++) kw_q[k] <= 64'h0;
      ready_q <= 1'b0;
      cnt_q   <= '0;
      pos_q   <= 3'd0;
      rci_q   <= 4'd0;
    end else if (cfg_hit) begin
      case (cfg_i.data.index)
        CFG_KEY_LENGTH: klen_q  <= cfg_i.data.value[1:0];
        CFG_KEY_WORD_0: kw_q[0] <= cfg_i.data.value;
        CFG_KEY_WORD_1: kw_q[1] <= cfg_i.data.value;
        CFG_KEY_WORD_2: kw_q[2] <= cfg_i.data.value;
        CFG_KEY_WORD_3: kw_q[3] <= cfg_i.data.value;
        default: ;
      endcase
      ready_q <= 1'b0;
      cnt_q   <= '0;
      pos_q   <= 3'd0;
      rci_q   <= 4'd0;
    end else if (expand) begin
      cnt_q <= cnt_q + RK_AW'(1);
      pos_q <= (pos_q == 3'(nk - 4'd1)) ? 3'd0 : pos_q + 3'd1;
      if (pos_q == 3'd0 && cnt_q >= RK_AW'(nk)) rci_q <= rci_q + 4'd1;
      if (cnt_q == total - RK_AW'(1)) ready_q <= 1'b1;
    end
  end

  // Store the word and advance the window
  always_ff @(posedge clk_i) begin
    if (expand) begin
      rk_q[cnt_q[RK_AW-1:0]] <= w;
      win_q[0] <= w;
      for (int k = 1; k < 8; k++) win_q[k] <= win_q[k-1];
    end
  end

  assign key_len_o    = klen_q;
  assign keys_ready_o = ready_q;
  assign rk_o         = rk_q;

endmodule
`default_nettype wire

/* design/aes_round.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// aes_round
// One registered cipher round, forward or inverse, with bypass past the end.
// ---------------------------------------------------------------------------
module aes_round import aes_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire round_ctl_t   ctl_i,
  input  wire logic [127:0] key_enc_i,
  input  wire logic [127:0] key_dec_i,
  input  wire logic         valid_i,
  input  wire logic         dec_i,
  input  wire logic [127:0] state_i,
  output logic              valid_o,
  output logic              dec_o,
  output logic [127:0]      state_o
);

  logic         valid_q;
  logic         dec_q;
  logic [127:0] state_q;
  logic [127:0] state_d;
  logic [127:0] fx;
  logic [127:0] ix;

  // Forward: sub/shift, mix, key. Inverse: sub/shift, key, mix.
  always_comb begin
    fx = sub_shift(state_i, 1'b0);
    if (!ctl_i.last) fx = mix_fwd(fx);
    fx = fx ^ key_enc_i;
    ix = sub_shift(state_i, 1'b1) ^ key_dec_i;
    if (!ctl_i.last) ix = mix_inv(ix);
    if (ctl_i.bypass) begin
      state_d = state_i;
    end else begin
      state_d = dec_i ? ix : fx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q   <= dec_i;
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;
  assign state_o = state_q;

endmodule
`default_nettype wire

/* design/aes_block_cipher.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// aes_block_cipher
// AES-128/192/256 ECB cipher, fully unrolled round pipeline.
// ---------------------------------------------------------------------------
// Usage:
//   cfg_i  writes key_length (index 0) and key words 0..3 (index 1..4);
//          always ready. Write only while no block is in flight.
//   in_i   takes one block per ready cycle: opcode 0 encrypts, 1 decrypts.
//   out_o  gives one result per block, in order.
// After reset and after each register write the key schedule runs one
// 32-bit word per cycle (44, 52 or 60 words for 128, 192 or 256 bit keys);
// in_i.ready stays low until it is done.
// Every key size uses the same path from input to output: one stage
// for the initial key add and fourteen round stages, rounds past the last
// one being bypassed. Throughput is one block per cycle unless stalled.
// When out_o is stalled the whole pipeline holds; no block is lost or
// repeated. in_i.ready drops while the output register is full and not
// taken, and while the key schedule runs.
// ---------------------------------------------------------------------------
module aes_block_cipher import aes_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aes_cfg_if.sink   cfg_i,
  aes_in_if.sink    in_i,
  aes_out_if.source out_o
);

  logic [1:0]   key_len;
  logic         keys_ready;
  logic [31:0]  rk [RK_WORDS];
  logic [127:0] rkey [MAX_ROUNDS + 1];
  logic [3:0]   nr;
  logic         en;

  logic         v   [MAX_ROUNDS + 1];
  logic         dec [MAX_ROUNDS + 1];
  logic [127:0] st  [MAX_ROUNDS + 1];

  logic         v0_q;
  logic         dec0_q;
  logic [127:0] st0_q;

  logic [127:0] key0_dec;
  logic [127:0] st0_d;

  aes_key_expand u_key (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .key_len_o    (key_len),
    .keys_ready_o (keys_ready),
    .rk_o         (rk)
  );

  for (genvar k = 0; k <= MAX_ROUNDS; k++) begin : g_rkey
    assign rkey[k] = {rk[4*k], rk[4*k+1], rk[4*k+2], rk[4*k+3]};
  end

  always_comb begin
    case (key_len)
      2'd0: begin
        nr       = 4'd10;
        key0_dec = rkey[10];
      end
      2'd1: begin
        nr       = 4'd12;
        key0_dec = rkey[12];
      end
      default: begin
        nr       = 4'd14;
        key0_dec = rkey[14];
      end
    endcase
  end

  // Global advance: hold everything while the output waits
  assign en         = !v[MAX_ROUNDS] || out_o.ready;
  assign in_i.ready = keys_ready && en;

  // Initial key add
  assign st0_d = {in_i.data.data_hi, in_i.data.data_lo} ^
                 (in_i.data.opcode ? key0_dec : rkey[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid && keys_ready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dec0_q <= in_i.data.opcode;
      st0_q  <= st0_d;
    end
  end

  assign v[0]   = v0_q;
  assign dec[0] = dec0_q;
  assign st[0]  = st0_q;

  // Round stages
  for (genvar r = 1; r <= MAX_ROUNDS; r++) begin : g_round
    localparam int K10 = (r <= 10) ? 10 - r : 0;
    localparam int K12 = (r <= 12) ? 12 - r : 0;
    localparam int K14 = 14 - r;

    round_ctl_t   ctl;
    logic [127:0] kdec;

    assign ctl.last   = (nr == 4'(r));
    assign ctl.bypass = (nr < 4'(r));

    always_comb begin
      case (key_len)
        2'd0:    kdec = rkey[K10];
        2'd1:    kdec = rkey[K12];
        default: kdec = rkey[K14];
      endcase
    end

    aes_round u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .ctl_i     (ctl),
      .key_enc_i (rkey[r]),
      .key_dec_i (kdec),
      .valid_i   (v[r-1]),
      .dec_i     (dec[r-1]),
      .state_i   (st[r-1]),
      .valid_o   (v[r]),
      .dec_o     (dec[r]),
      .state_o   (st[r])
    );
  end

  assign out_o.valid       = v[MAX_ROUNDS];
  assign out_o.data.out_hi = st[MAX_ROUNDS][127:64];
  assign out_o.data.out_lo = st[MAX_ROUNDS][63:0];

endmodule
`default_nettype wire

/* bench/aes_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aes_checker
// Watches the key, block and result channels of the AES cipher, expands the
// key on its own, predicts each result and compares it with what comes out.
// ---------------------------------------------------------------------------
module aes_checker import aes_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aes_cfg_if.sink   cfg_mon,
  aes_in_if.sink    blk_mon,
  aes_out_if.sink   res_mon,
  output int        fail_cnt_o,
  output int        res_cnt_o,
  output int        pending_o
);

  logic [1:0]  key_len;
  logic [63:0] key_words [4];
  logic [31:0] sched [RK_WORDS];
  logic        sched_ok;
  out_item_t   expected_q [$];

  // S-box tables built in the bench
  logic [7:0] fsb [256];
  logic [7:0] isb [256];

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ ({8{x[7]}} & 8'h1b);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] p;
    p = 0;
    for (int b = 0; b < 8; b++) begin
      if (y[b]) p ^= x;
      x = xt(x);
    end
    return p;
  endfunction

  initial begin
    logic [7:0] inv, v;
    for (int i = 0; i < 256; i++) begin
      inv = 0;
      if (i != 0) begin
        for (int j = 1; j < 256; j++) begin
          if (gf_mul(i[7:0], j[7:0]) == 8'h01) inv = j[7:0];
        end
      end
      v = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
          {inv[3:0], inv[7:4]} ^ 8'h63;
      fsb[i] = v;
      isb[v] = i[7:0];
    end
  end

  function automatic int rounds_for(input logic [1:0] kl);
    return (kl == 0) ? 10 : (kl == 1) ? 12 : 14;
  endfunction

  function automatic logic [31:0] subw(input logic [31:0] w);
    return {fsb[w[31:24]], fsb[w[23:16]], fsb[w[15:8]], fsb[w[7:0]]};
  endfunction

  // Expand the configured key into the round-key schedule
  task automatic expand_schedule();
    int nk, total;
    logic [31:0] t;
    logic [7:0]  rc;
    nk = (key_len == 0) ? 4 : (key_len == 1) ? 6 : 8;
    total = 4 * (rounds_for(key_len) + 1);
    for (int i = 0; i < nk; i++) begin
      sched[i] = (i % 2) ? key_words[i / 2][31:0] : key_words[i / 2][63:32];
    end
    rc = 8'h01;
    for (int i = nk; i < total; i++) begin
      t = sched[i - 1];
      if (i % nk == 0) begin
        t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = xt(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = subw(t);
      end
      sched[i] = sched[i - nk] ^ t;
    end
    sched_ok = 1'b1;
  endtask

  function automatic logic [127:0] add_rk(input logic [127:0] s, input int r);
    return s ^ {sched[4 * r], sched[4 * r + 1], sched[4 * r + 2], sched[4 * r + 3]};
  endfunction

  function automatic logic [7:0] byte_of(input logic [127:0] s, input int b);
    return s[127 - 8 * b -: 8];
  endfunction

  function automatic logic [127:0] shift_sub(input logic [127:0] s, input logic dec);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = dec ? ((c + 4 - r) % 4) : ((c + r) % 4);
        t[127 - 8 * (4 * c + r) -: 8] = dec ? isb[byte_of(s, 4 * src + r)]
                                            : fsb[byte_of(s, 4 * src + r)];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s, input logic dec);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] m [4];
    if (dec) begin
      m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    end else begin
      m = '{8'h02, 8'h03, 8'h01, 8'h01};
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) a[j] = byte_of(s, 4 * c + j);
      for (int j = 0; j < 4; j++) begin
        t[127 - 8 * (4 * c + j) -: 8] = gf_mul(a[j], m[0]) ^
          gf_mul(a[(j + 1) % 4], m[1]) ^ gf_mul(a[(j + 2) % 4], m[2]) ^
          gf_mul(a[(j + 3) % 4], m[3]);
      end
    end
    return t;
  endfunction

  // Run one block through the forward or inverse cipher
  function automatic out_item_t cipher_block(input in_item_t it);
    logic [127:0] s;
    int nr;
    out_item_t o;
    nr = rounds_for(key_len);
    s = {it.data_hi, it.data_lo};
    if (!it.opcode) begin
      s = add_rk(s, 0);
      for (int r = 1; r < nr; r++) s = add_rk(mix(shift_sub(s, 1'b0), 1'b0), r);
      s = add_rk(shift_sub(s, 1'b0), nr);
    end else begin
      s = add_rk(s, nr);
      for (int r = nr - 1; r > 0; r--) s = mix(add_rk(shift_sub(s, 1'b1), r), 1'b1);
      s = add_rk(shift_sub(s, 1'b1), 0);
    end
    o.out_hi = s[127:64];
    o.out_lo = s[63:0];
    return o;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s at %0t: got %h expected %h", what, $time, got, exp);
    fail_cnt_o++;
  endtask

  assign pending_o = expected_q.size();

  // Track keys, predict blocks and compare results
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      key_len = 0;
      key_words = '{default: '0};
      sched_ok = 1'b0;
      expected_q.delete();
      fail_cnt_o = 0;
      res_cnt_o = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.data.index)
          CFG_KEY_LENGTH: begin key_len = cfg_mon.data.value[1:0]; sched_ok = 1'b0; end
          CFG_KEY_WORD_0: begin key_words[0] = cfg_mon.data.value; sched_ok = 1'b0; end
          CFG_KEY_WORD_1: begin key_words[1] = cfg_mon.data.value; sched_ok = 1'b0; end
          CFG_KEY_WORD_2: begin key_words[2] = cfg_mon.data.value; sched_ok = 1'b0; end
          CFG_KEY_WORD_3: begin key_words[3] = cfg_mon.data.value; sched_ok = 1'b0; end
          default: ;
        endcase
      end
      if (blk_mon.valid && blk_mon.ready) begin
        if (!sched_ok) expand_schedule();
        expected_q.push_back(cipher_block(blk_mon.data));
      end
      if (res_mon.valid && res_mon.ready) begin
        res_cnt_o++;
        if (expected_q.size() == 0) begin
          report("unexpected result", res_mon.data.out_hi, 64'h0);
        end else begin
          e = expected_q.pop_front();
          if (res_mon.data.out_hi !== e.out_hi) report("out_hi", res_mon.data.out_hi, e.out_hi);
          if (res_mon.data.out_lo !== e.out_lo) report("out_lo", res_mon.data.out_lo, e.out_lo);
        end
      end
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives key settings and encrypt/decrypt blocks into the AES cipher with
// random gaps and output stalls; the checker predicts and compares results.
// ---------------------------------------------------------------------------
module tb_top import aes_pkg::*;;

  localparam int LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt, res_cnt, pending, idle_cycles, sent;
  logic hold_long;

  aes_cfg_if cfg_ch ();
  aes_in_if  blk_ch ();
  aes_out_if res_ch ();

  aes_block_cipher dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch.sink),
    .in_i  (blk_ch.sink),
    .out_o (res_ch.source)
  );

  aes_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_mon   (cfg_ch.sink),
    .blk_mon   (blk_ch.sink),
    .res_mon   (res_ch.sink),
    .fail_cnt_o(fail_cnt),
    .res_cnt_o (res_cnt),
    .pending_o (pending)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: v};
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_key(input logic [1:0] kl, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    write_reg(CFG_KEY_LENGTH, {62'h0, kl});
    write_reg(CFG_KEY_WORD_0, k0);
    write_reg(CFG_KEY_WORD_1, k1);
    write_reg(CFG_KEY_WORD_2, k2);
    write_reg(CFG_KEY_WORD_3, k3);
  endtask

  // Offer one block, with an optional gap first
  task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo,
                            input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      blk_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    blk_ch.valid <= 1'b1;
    blk_ch.data  <= '{opcode: op, data_hi: hi, data_lo: lo};
    @(posedge clk_i);
    while (!blk_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    blk_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Random result stalls, with one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        res_ch.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_long = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  // Stall watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((blk_ch.valid && blk_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] k [4];
    logic [1:0]  kl;
    sent = 0;
    hold_long = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    blk_ch.valid = 1'b0;
    blk_ch.data  = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Known vectors from the standard, then field extremes
    load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0);
    send_block(1'b0, 64'h0, 64'h0, 1'b0);
    send_block(1'b1, '1, '1, 1'b0);
    drain();
    load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '1);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1'b0);
    drain();
    load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
             64'h18191a1b1c1d1e1f);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b0);
    drain();
    // Length code 3 acts as 256 bits; all-ones key
    load_key(2'd3, '1, '1, '1, '1);
    send_block(1'b0, '1, 64'h0, 1'b0);
    send_block(1'b1, 64'h0, '1, 1'b0);
    drain();
    // Out-of-range index is ignored, and a key-length write with high bits set
    write_reg(cfg_idx_e'(3'd5), '1);
    write_reg(cfg_idx_e'(3'd7), 64'h0);
    write_reg(CFG_KEY_LENGTH, 64'hfffffffffffffffc);
    send_block(1'b0, 64'h8000000000000000, 64'h1, 1'b0);
    send_block(1'b1, 64'h1, 64'h8000000000000000, 1'b0);
    drain();

    // Random phases with new keys; one phase holds the output off for long
    for (int ph = 0; ph < 12; ph++) begin
      kl = $urandom_range(0, 3);
      for (int w = 0; w < 4; w++) k[w] = rand64();
      load_key(kl, k[0], k[1], k[2], k[3]);
      if (ph == 3) hold_long = 1'b1;
      for (int n = 0; n < 78; n++) begin
        send_block($urandom_range(0, 1), rand64(), rand64(), ph % 4 != 1);
      end
      drain();
    end

    $display("Covered %0d blocks and %0d results over 16 key settings,", sent, res_cnt);
    $display("all key lengths, both directions, random gaps and a long output stall.");
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
